// ===== rtl/mbi_pkg.sv =====
package mbi_pkg;

  // Default burst length.
  localparam int SAMPLES_PER_BURST = 30;

  // Field widths.
  localparam int READING_W = 10;
  localparam int INTERVAL_W = 16;
  localparam int LEVEL_W = 12;
  localparam int SUM_W = 18;
  localparam int BAND_W = 2;

  // Configuration port.
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_READING_INTERVAL = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLING_INTERVAL = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_UPDATE_INTERVAL = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DRY_LEVEL = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WET_LEVEL = 3'd4;

  // Register reset values.
  localparam logic [INTERVAL_W-1:0] RST_READING_INTERVAL = 16'd30000;
  localparam logic [INTERVAL_W-1:0] RST_SAMPLING_INTERVAL = 16'd250;
  localparam logic [INTERVAL_W-1:0] RST_UPDATE_INTERVAL = 16'd250;
  localparam logic [LEVEL_W-1:0] RST_DRY_LEVEL = 12'd520;
  localparam logic [LEVEL_W-1:0] RST_WET_LEVEL = 12'd260;

  // Band codes.
  localparam logic [BAND_W-1:0] BAND_TOO_WET = 2'd0;
  localparam logic [BAND_W-1:0] BAND_OK = 2'd1;
  localparam logic [BAND_W-1:0] BAND_WARNING = 2'd2;
  localparam logic [BAND_W-1:0] BAND_ALERT = 2'd3;

  // Lamp bits: green, yellow, red from the low end.
  localparam logic [2:0] LAMP_GREEN = 3'b001;
  localparam logic [2:0] LAMP_YELLOW = 3'b010;
  localparam logic [2:0] LAMP_RED = 3'b100;

  // Timer settings handed from the register file to the tick logic.
  typedef struct packed {
    logic [INTERVAL_W-1:0] reading_interval;
    logic [INTERVAL_W-1:0] sampling_interval;
    logic [INTERVAL_W-1:0] update_interval;
  } mbi_timing_t;

  // One result item.
  typedef struct packed {
    logic green_on;
    logic yellow_on;
    logic red_on;
    logic verdict_valid;
    logic [BAND_W-1:0] band;
    logic [SUM_W-1:0] burst_sum;
  } mbi_result_t;

endpackage

// ===== rtl/mbi_if.sv =====
// Input channel: one millisecond tick with the converter reading.
interface mbi_in_if;
  logic valid;
  logic ready;
  logic [mbi_pkg::READING_W-1:0] adc_reading;

  modport source (output valid, output adc_reading, input ready);
  modport sink (input valid, input adc_reading, output ready);
endinterface

// Result channel: lamp levels and the burst verdict for one tick.
interface mbi_out_if;
  logic valid;
  logic ready;
  logic green_on;
  logic yellow_on;
  logic red_on;
  logic verdict_valid;
  logic [mbi_pkg::BAND_W-1:0] band;
  logic [mbi_pkg::SUM_W-1:0] burst_sum;

  modport source (output valid, output green_on, output yellow_on, output red_on,
                  output verdict_valid, output band, output burst_sum, input ready);
  modport sink (input valid, input green_on, input yellow_on, input red_on,
                input verdict_valid, input band, input burst_sum, output ready);
endinterface

// ===== rtl/mbi_cfg.sv =====
module mbi_cfg #(
  parameter int SAMPLES_PER_BURST = mbi_pkg::SAMPLES_PER_BURST,
  localparam int CNT_W = $clog2(SAMPLES_PER_BURST + 1),
  localparam int THR_W = mbi_pkg::LEVEL_W + CNT_W
) (
  input  logic clk,
  input  logic rst_n,
  input  logic cfg_we,
  input  logic [mbi_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [mbi_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output mbi_pkg::mbi_timing_t timing_o,
  output logic [THR_W-1:0] thr_alert_o,
  output logic [THR_W-1:0] thr_warn_o,
  output logic [THR_W-1:0] thr_ok_o
);

  mbi_pkg::mbi_timing_t timing_r;
  logic [mbi_pkg::LEVEL_W-1:0] dry_r;
  logic [mbi_pkg::LEVEL_W-1:0] wet_r;
  logic [THR_W-1:0] thr_alert_r;
  logic [THR_W-1:0] thr_warn_r;
  logic [THR_W-1:0] thr_ok_r;

  logic [mbi_pkg::LEVEL_W-1:0] step;
  logic [mbi_pkg::LEVEL_W-1:0] lvl_alert;
  logic [mbi_pkg::LEVEL_W-1:0] lvl_warn;
  logic [mbi_pkg::LEVEL_W-1:0] lvl_ok;
  logic [THR_W-1:0] thr_alert_nxt;
  logic [THR_W-1:0] thr_warn_nxt;
  logic [THR_W-1:0] thr_ok_nxt;

  // Register writes; unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timing_r.reading_interval <= mbi_pkg::RST_READING_INTERVAL;
      timing_r.sampling_interval <= mbi_pkg::RST_SAMPLING_INTERVAL;
      timing_r.update_interval <= mbi_pkg::RST_UPDATE_INTERVAL;
      dry_r <= mbi_pkg::RST_DRY_LEVEL;
      wet_r <= mbi_pkg::RST_WET_LEVEL;
    end else if (cfg_we) begin
      case (cfg_idx)
        mbi_pkg::REG_READING_INTERVAL: timing_r.reading_interval <= cfg_wdata;
        mbi_pkg::REG_SAMPLING_INTERVAL: timing_r.sampling_interval <= cfg_wdata;
        mbi_pkg::REG_UPDATE_INTERVAL: timing_r.update_interval <= cfg_wdata;
        mbi_pkg::REG_DRY_LEVEL: dry_r <= cfg_wdata[mbi_pkg::LEVEL_W-1:0];
        mbi_pkg::REG_WET_LEVEL: wet_r <= cfg_wdata[mbi_pkg::LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

  // Band step is a quarter of the dry-wet span; the three levels never go negative
  // because three steps stay below the dry level.
  always_comb begin
    step = (dry_r > wet_r) ? ((dry_r - wet_r) >> 2) : '0;
    lvl_alert = dry_r - step;
    lvl_warn = dry_r - {step[mbi_pkg::LEVEL_W-2:0], 1'b0};
    lvl_ok = dry_r - ({step[mbi_pkg::LEVEL_W-2:0], 1'b0} + step);
    thr_alert_nxt = THR_W'(lvl_alert) * THR_W'(SAMPLES_PER_BURST);
    thr_warn_nxt = THR_W'(lvl_warn) * THR_W'(SAMPLES_PER_BURST);
    thr_ok_nxt = THR_W'(lvl_ok) * THR_W'(SAMPLES_PER_BURST);
  end

  // Thresholds are registered from the levels, so they follow them in the next cycle.
  always_ff @(posedge clk) begin
    thr_alert_r <= thr_alert_nxt;
    thr_warn_r <= thr_warn_nxt;
    thr_ok_r <= thr_ok_nxt;
  end

  assign timing_o = timing_r;
  assign thr_alert_o = thr_alert_r;
  assign thr_warn_o = thr_warn_r;
  assign thr_ok_o = thr_ok_r;

endmodule

// ===== rtl/mbi_tick.sv =====
module mbi_tick #(
  parameter int SAMPLES_PER_BURST = mbi_pkg::SAMPLES_PER_BURST,
  localparam int CNT_W = $clog2(SAMPLES_PER_BURST + 1),
  localparam int THR_W = mbi_pkg::LEVEL_W + CNT_W
) (
  input  logic clk,
  input  logic rst_n,
  input  logic adv_i,
  input  logic [mbi_pkg::READING_W-1:0] reading_i,
  input  mbi_pkg::mbi_timing_t timing_i,
  input  logic [THR_W-1:0] thr_alert_i,
  input  logic [THR_W-1:0] thr_warn_i,
  input  logic [THR_W-1:0] thr_ok_i,
  output mbi_pkg::mbi_result_t res_o
);

  localparam int CMP_W = (THR_W > mbi_pkg::SUM_W) ? THR_W : mbi_pkg::SUM_W;
  localparam int SAMPLE_W = mbi_pkg::READING_W + 2;

  typedef enum logic [2:0] {
    MODE_OFF = 3'd0,
    MODE_WET_ON = 3'd1,
    MODE_WET_OFF = 3'd2,
    MODE_OK = 3'd3,
    MODE_WARNING = 3'd4,
    MODE_ALERT_ON = 3'd5,
    MODE_ALERT_OFF = 3'd6
  } mode_t;

  logic [mbi_pkg::INTERVAL_W-1:0] since_reading_r, since_reading_nxt;
  logic [mbi_pkg::INTERVAL_W-1:0] since_sample_r, since_sample_nxt;
  logic [mbi_pkg::INTERVAL_W-1:0] since_update_r, since_update_nxt;
  logic active_r, active_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [1:0] phase_r, phase_nxt;
  logic [mbi_pkg::SUM_W-1:0] sum_r, sum_nxt;
  mode_t mode_r, mode_nxt;
  logic [2:0] lamp_r, lamp_nxt;

  logic [CNT_W-1:0] cnt_inc;
  logic [SAMPLE_W-1:0] sample;
  logic [mbi_pkg::SUM_W-1:0] sum_inc;
  mbi_pkg::mbi_result_t res;

  function automatic logic [mbi_pkg::INTERVAL_W-1:0] sat_inc(
    input logic [mbi_pkg::INTERVAL_W-1:0] v
  );
    return (&v) ? v : v + 1'b1;
  endfunction

  // Next state and result for one tick.
  always_comb begin
    since_reading_nxt = sat_inc(since_reading_r);
    since_sample_nxt = sat_inc(since_sample_r);
    since_update_nxt = sat_inc(since_update_r);
    active_nxt = active_r;
    cnt_nxt = cnt_r;
    phase_nxt = phase_r;
    sum_nxt = sum_r;
    mode_nxt = mode_r;
    lamp_nxt = lamp_r;
    res.verdict_valid = 1'b0;
    res.band = mbi_pkg::BAND_TOO_WET;
    res.burst_sum = '0;

    sample = {1'b0, reading_i, 1'b0} + {2'b00, reading_i};
    sum_inc = sum_r + mbi_pkg::SUM_W'(sample);
    cnt_inc = cnt_r + 1'b1;

    // Chase lamp during a burst follows the sample count mod 3.
    if (active_r) begin
      case (phase_r)
        2'd0: lamp_nxt = mbi_pkg::LAMP_RED;
        2'd1: lamp_nxt = mbi_pkg::LAMP_YELLOW;
        default: lamp_nxt = mbi_pkg::LAMP_GREEN;
      endcase
    end

    // Indicator update and blink toggle.
    if (since_update_nxt >= timing_i.update_interval) begin
      case (mode_r)
        MODE_OK: lamp_nxt = lamp_nxt | mbi_pkg::LAMP_GREEN;
        MODE_WET_OFF: begin
          lamp_nxt = lamp_nxt | mbi_pkg::LAMP_GREEN;
          mode_nxt = MODE_WET_ON;
        end
        MODE_WET_ON: begin
          lamp_nxt = lamp_nxt & ~mbi_pkg::LAMP_GREEN;
          mode_nxt = MODE_WET_OFF;
        end
        MODE_WARNING: lamp_nxt = lamp_nxt | mbi_pkg::LAMP_YELLOW;
        MODE_ALERT_ON: begin
          lamp_nxt = lamp_nxt & ~mbi_pkg::LAMP_RED;
          mode_nxt = MODE_ALERT_OFF;
        end
        MODE_ALERT_OFF: begin
          lamp_nxt = lamp_nxt | mbi_pkg::LAMP_RED;
          mode_nxt = MODE_ALERT_ON;
        end
        default: lamp_nxt = '0;
      endcase
      since_update_nxt = '0;
    end

    // Burst sampling, classification and start.
    if (active_r) begin
      if (since_sample_nxt >= timing_i.sampling_interval) begin
        since_sample_nxt = '0;
        sum_nxt = sum_inc;
        cnt_nxt = cnt_inc;
        phase_nxt = (phase_r == 2'd2) ? 2'd0 : phase_r + 2'd1;
        if (cnt_inc == CNT_W'(SAMPLES_PER_BURST)) begin
          res.verdict_valid = 1'b1;
          res.burst_sum = sum_inc;
          if (CMP_W'(sum_inc) >= CMP_W'(thr_alert_i)) begin
            res.band = mbi_pkg::BAND_ALERT;
            mode_nxt = MODE_ALERT_OFF;
          end else if (CMP_W'(sum_inc) >= CMP_W'(thr_warn_i)) begin
            res.band = mbi_pkg::BAND_WARNING;
            mode_nxt = MODE_WARNING;
          end else if (CMP_W'(sum_inc) >= CMP_W'(thr_ok_i)) begin
            res.band = mbi_pkg::BAND_OK;
            mode_nxt = MODE_OK;
          end else begin
            res.band = mbi_pkg::BAND_TOO_WET;
            mode_nxt = MODE_WET_OFF;
          end
          lamp_nxt = '0;
          cnt_nxt = '0;
          phase_nxt = 2'd0;
          sum_nxt = '0;
          active_nxt = 1'b0;
        end
      end
    end else if (since_reading_nxt >= timing_i.reading_interval) begin
      active_nxt = 1'b1;
      since_reading_nxt = '0;
      since_sample_nxt = timing_i.sampling_interval;
      cnt_nxt = '0;
      phase_nxt = 2'd0;
      sum_nxt = '0;
    end

    res.green_on = lamp_nxt[0];
    res.yellow_on = lamp_nxt[1];
    res.red_on = lamp_nxt[2];
  end

  // State advances once per transferred tick.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      since_reading_r <= '0;
      since_sample_r <= '0;
      since_update_r <= '0;
      active_r <= 1'b0;
      cnt_r <= '0;
      phase_r <= 2'd0;
      sum_r <= '0;
      mode_r <= MODE_OFF;
      lamp_r <= '0;
    end else if (adv_i) begin
      since_reading_r <= since_reading_nxt;
      since_sample_r <= since_sample_nxt;
      since_update_r <= since_update_nxt;
      active_r <= active_nxt;
      cnt_r <= cnt_nxt;
      phase_r <= phase_nxt;
      sum_r <= sum_nxt;
      mode_r <= mode_nxt;
      lamp_r <= lamp_nxt;
    end
  end

  assign res_o = res;

`ifndef ASSERT_OFF
  // Outside a burst the accumulator and count sit at zero.
  a_idle_clear: assert property (@(posedge clk) disable iff (!rst_n)
    !active_r |-> (cnt_r == '0 && sum_r == '0 && phase_r == 2'd0))
    else $error("accumulator not clear outside a burst");

  // A verdict always ends the burst.
  a_verdict_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (adv_i && res.verdict_valid) |=> !active_r)
    else $error("burst still active after verdict");

  // The sample count never passes the burst length.
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(SAMPLES_PER_BURST - 1))
    else $error("sample count out of range");
`endif

endmodule

// ===== rtl/moisture_band_indicator_core.sv =====
// Moisture band indicator. Each transfer on in_ch is one millisecond tick carrying the
// converter reading, and each tick yields exactly one result on out_ch with the three
// lamp levels and, on the tick that ends a sampling burst, the burst sum and its band.
// A new tick is taken every clock cycle unless backpressure on out_ch stalls the input.
// A tick passes from the input register through a single pass of tick logic into the
// result register, from which its result is presented; backpressure on out_ch stalls
// the input through a one-entry hold in each register. The band thresholds are
// registered from the dry and wet level registers, which a configuration write updates.
module moisture_band_indicator_core #(
  parameter int SAMPLES_PER_BURST = mbi_pkg::SAMPLES_PER_BURST
) (
  input  logic clk,
  input  logic rst_n,
  mbi_in_if.sink in_ch,
  mbi_out_if.source out_ch,
  input  logic cfg_we,
  input  logic [mbi_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [mbi_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  localparam int CNT_W = $clog2(SAMPLES_PER_BURST + 1);
  localparam int THR_W = mbi_pkg::LEVEL_W + CNT_W;

  mbi_pkg::mbi_timing_t timing;
  logic [THR_W-1:0] thr_alert;
  logic [THR_W-1:0] thr_warn;
  logic [THR_W-1:0] thr_ok;

  logic in_valid_r, in_valid_nxt;
  logic [mbi_pkg::READING_W-1:0] in_reading_r;
  logic out_valid_r, out_valid_nxt;
  mbi_pkg::mbi_result_t out_res_r;
  mbi_pkg::mbi_result_t res;
  logic out_free;
  logic adv;
  logic in_xfer;

  mbi_cfg #(.SAMPLES_PER_BURST(SAMPLES_PER_BURST)) u_cfg (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_we(cfg_we),
    .cfg_idx(cfg_idx),
    .cfg_wdata(cfg_wdata),
    .timing_o(timing),
    .thr_alert_o(thr_alert),
    .thr_warn_o(thr_warn),
    .thr_ok_o(thr_ok)
  );

  mbi_tick #(.SAMPLES_PER_BURST(SAMPLES_PER_BURST)) u_tick (
    .clk(clk),
    .rst_n(rst_n),
    .adv_i(adv),
    .reading_i(in_reading_r),
    .timing_i(timing),
    .thr_alert_i(thr_alert),
    .thr_warn_i(thr_warn),
    .thr_ok_i(thr_ok),
    .res_o(res)
  );

  // Handshake: a held tick moves on when the result register is free or draining.
  assign out_free = !out_valid_r || out_ch.ready;
  assign adv = in_valid_r && out_free;
  assign in_ch.ready = !in_valid_r || adv;
  assign in_xfer = in_ch.valid && in_ch.ready;

  always_comb begin
    in_valid_nxt = in_xfer ? 1'b1 : (adv ? 1'b0 : in_valid_r);
    out_valid_nxt = adv ? 1'b1 : (out_ch.ready ? 1'b0 : out_valid_r);
  end

  // Input and result registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      in_reading_r <= in_ch.adc_reading;
    end
    if (adv) begin
      out_res_r <= res;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.green_on = out_res_r.green_on;
  assign out_ch.yellow_on = out_res_r.yellow_on;
  assign out_ch.red_on = out_res_r.red_on;
  assign out_ch.verdict_valid = out_res_r.verdict_valid;
  assign out_ch.band = out_res_r.band;
  assign out_ch.burst_sum = out_res_r.burst_sum;

`ifndef ASSERT_OFF
  // A full pipeline with a stalled result must refuse new ticks.
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid_r && out_valid_r && !out_ch.ready) |-> !in_ch.ready)
    else $error("tick taken while pipeline is full");

  // A result that was not taken stays in the result register.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready) |=> out_valid_r)
    else $error("pending result dropped");

  // A stalled result keeps its payload.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready) |=> $stable(out_res_r))
    else $error("pending result changed while stalled");
`endif

endmodule

// ===== verif/tb_top.sv =====
module tb_top;

  localparam int HALF_PERIOD = 5;
  localparam int RESET_CYCLES = 8;
  localparam int ITEM_GOAL = 1450;
  localparam int MAX_PHASES = 60;
  localparam int RUN_LIMIT = 1000000;
  localparam int SETTLE_CYCLES = 4;
  localparam int TAIL_CYCLES = 10;
  localparam logic [mbi_pkg::READING_W-1:0] EDGE_READINGS [4] =
    '{10'h000, 10'h3FF, 10'h155, 10'h2AA};

  // Who idles during a phase of the run.
  typedef enum int {FLOW_FREE, FLOW_SRC_IDLE, FLOW_SNK_STALL, FLOW_BOTH} flow_t;

  // Predicts lamp levels and burst verdicts, and checks results against them.
  class moisture_scoreboard;
    typedef enum logic [2:0] {
      IND_OFF, IND_WET_ON, IND_WET_OFF, IND_OK, IND_WARNING, IND_ALERT_ON, IND_ALERT_OFF
    } ind_mode_t;

    logic [mbi_pkg::INTERVAL_W-1:0] reading_ivl, sampling_ivl, update_ivl;
    logic [mbi_pkg::LEVEL_W-1:0] dry_lvl, wet_lvl;
    logic [mbi_pkg::INTERVAL_W-1:0] since_reading, since_sample, since_update;
    bit burst_on;
    logic [6:0] count;
    logic [mbi_pkg::SUM_W-1:0] sum;
    ind_mode_t mode;
    logic [2:0] lamps;
    mbi_pkg::mbi_result_t expected_q[$];
    int unsigned errors, checked;

    function new();
      reading_ivl = mbi_pkg::RST_READING_INTERVAL;
      sampling_ivl = mbi_pkg::RST_SAMPLING_INTERVAL;
      update_ivl = mbi_pkg::RST_UPDATE_INTERVAL;
      dry_lvl = mbi_pkg::RST_DRY_LEVEL;
      wet_lvl = mbi_pkg::RST_WET_LEVEL;
      since_reading = '0;
      since_sample = '0;
      since_update = '0;
      burst_on = 1'b0;
      count = '0;
      sum = '0;
      mode = IND_OFF;
      lamps = '0;
      errors = 0;
      checked = 0;
    endfunction

    function void write_reg(logic [mbi_pkg::CFG_IDX_W-1:0] idx,
                            logic [mbi_pkg::CFG_DATA_W-1:0] data);
      case (idx)
        mbi_pkg::REG_READING_INTERVAL: reading_ivl = data;
        mbi_pkg::REG_SAMPLING_INTERVAL: sampling_ivl = data;
        mbi_pkg::REG_UPDATE_INTERVAL: update_ivl = data;
        mbi_pkg::REG_DRY_LEVEL: dry_lvl = data[mbi_pkg::LEVEL_W-1:0];
        mbi_pkg::REG_WET_LEVEL: wet_lvl = data[mbi_pkg::LEVEL_W-1:0];
        default: ;
      endcase
    endfunction

    // Millisecond timers stop at their top value.
    static function logic [mbi_pkg::INTERVAL_W-1:0] bump(
      logic [mbi_pkg::INTERVAL_W-1:0] v
    );
      return (v == '1) ? v : v + 1'b1;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    // One tick: timers, chase lamp, indicator update, then the burst logic.
    function void note_tick(logic [mbi_pkg::READING_W-1:0] reading);
      mbi_pkg::mbi_result_t res;
      int unsigned dry, step, n;
      res = '0;
      since_reading = bump(since_reading);
      since_sample = bump(since_sample);
      since_update = bump(since_update);

      // While a burst runs, the chase lamp sets the lamps; the refresh below may light others.
      if (burst_on) begin
        case (count % 3)
          0: lamps = mbi_pkg::LAMP_RED;
          1: lamps = mbi_pkg::LAMP_YELLOW;
          default: lamps = mbi_pkg::LAMP_GREEN;
        endcase
      end

      // Indicator refresh; the blinking modes toggle here.
      if (since_update >= update_ivl) begin
        case (mode)
          IND_OK: lamps = lamps | mbi_pkg::LAMP_GREEN;
          IND_WET_OFF: begin
            lamps = lamps | mbi_pkg::LAMP_GREEN;
            mode = IND_WET_ON;
          end
          IND_WET_ON: begin
            lamps = lamps & ~mbi_pkg::LAMP_GREEN;
            mode = IND_WET_OFF;
          end
          IND_WARNING: lamps = lamps | mbi_pkg::LAMP_YELLOW;
          IND_ALERT_ON: begin
            lamps = lamps & ~mbi_pkg::LAMP_RED;
            mode = IND_ALERT_OFF;
          end
          IND_ALERT_OFF: begin
            lamps = lamps | mbi_pkg::LAMP_RED;
            mode = IND_ALERT_ON;
          end
          default: lamps = '0;
        endcase
        since_update = '0;
      end

      // Sampling and classification, or the start of a new burst.
      if (burst_on) begin
        if (since_sample >= sampling_ivl) begin
          sum = sum + mbi_pkg::SUM_W'(reading) * mbi_pkg::SUM_W'(3);
          count = count + 1'b1;
          since_sample = '0;
          if (count >= mbi_pkg::SAMPLES_PER_BURST) begin
            dry = 32'(dry_lvl);
            n = 32'(count);
            step = (dry_lvl > wet_lvl) ? (dry - 32'(wet_lvl)) / 4 : 0;
            if (sum >= (dry - step) * n) begin
              res.band = mbi_pkg::BAND_ALERT;
              mode = IND_ALERT_OFF;
            end else if (sum >= (dry - 2 * step) * n) begin
              res.band = mbi_pkg::BAND_WARNING;
              mode = IND_WARNING;
            end else if (sum >= (dry - 3 * step) * n) begin
              res.band = mbi_pkg::BAND_OK;
              mode = IND_OK;
            end else begin
              res.band = mbi_pkg::BAND_TOO_WET;
              mode = IND_WET_OFF;
            end
            res.verdict_valid = 1'b1;
            res.burst_sum = sum;
            lamps = '0;
            count = '0;
            sum = '0;
            burst_on = 1'b0;
          end
        end
      end else if (since_reading >= reading_ivl) begin
        burst_on = 1'b1;
        since_reading = '0;
        since_sample = sampling_ivl;
        count = '0;
        sum = '0;
      end

      res.green_on = lamps[0];
      res.yellow_on = lamps[1];
      res.red_on = lamps[2];
      expected_q.push_back(res);
    endfunction

    task report(string msg);
      errors++;
      $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task compare_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want)
        report($sformatf("%s on result %0d: got %0h, expected %0h",
                         name, checked, got, want));
    endtask

    task check_result(mbi_pkg::mbi_result_t got);
      mbi_pkg::mbi_result_t want;
      if (expected_q.size() == 0) begin
        report("result transfer with no tick outstanding");
        return;
      end
      want = expected_q.pop_front();
      compare_field("green_on", 32'(got.green_on), 32'(want.green_on));
      compare_field("yellow_on", 32'(got.yellow_on), 32'(want.yellow_on));
      compare_field("red_on", 32'(got.red_on), 32'(want.red_on));
      compare_field("verdict_valid", 32'(got.verdict_valid), 32'(want.verdict_valid));
      compare_field("band", 32'(got.band), 32'(want.band));
      compare_field("burst_sum", 32'(got.burst_sum), 32'(want.burst_sum));
      checked++;
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [mbi_pkg::CFG_IDX_W-1:0] cfg_idx;
  logic [mbi_pkg::CFG_DATA_W-1:0] cfg_wdata;
  int unsigned cycle_count = 0;
  int unsigned items_sent = 0;
  int base_reading = 0;
  int base_left = 0;
  flow_t flow = FLOW_FREE;
  mbi_pkg::mbi_result_t seen_result;
  moisture_scoreboard sb = new();

  mbi_in_if in_ch();
  mbi_out_if out_ch();

  moisture_band_indicator_core u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .out_ch(out_ch),
    .cfg_we(cfg_we),
    .cfg_idx(cfg_idx),
    .cfg_wdata(cfg_wdata)
  );

  always #(HALF_PERIOD) clk = ~clk;

  // Run limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    wait (cycle_count == RUN_LIMIT);
    $display("FAIL");
    $finish;
  end

  // Random hold-off for either side, by the idling pattern of the phase.
  function automatic bit hold_off(bit is_sender);
    int pct;
    pct = 0;
    if (flow == FLOW_BOTH) pct = 25;
    else if (flow == (is_sender ? FLOW_SRC_IDLE : FLOW_SNK_STALL)) pct = 88;
    return $urandom_range(0, 99) < pct;
  endfunction

  function automatic logic [mbi_pkg::READING_W-1:0] clamp_reading(int v);
    if (v < 0) return '0;
    if (v > 1023) return '1;
    return mbi_pkg::READING_W'(v);
  endfunction

  // Readings hover around a band threshold or the wet level for a while, with some noise.
  function automatic logic [mbi_pkg::READING_W-1:0] next_reading();
    int step, target;
    if (base_left == 0) begin
      base_left = $urandom_range(20, 70);
      step = (sb.dry_lvl > sb.wet_lvl) ? (int'(sb.dry_lvl) - int'(sb.wet_lvl)) / 4 : 0;
      target = int'(sb.dry_lvl) - int'($urandom_range(1, 4)) * step
               + int'($urandom_range(0, 12)) - 6;
      base_reading = ($urandom_range(0, 9) < 2) ? int'($urandom_range(0, 1023))
                                                 : int'(clamp_reading(target / 3));
    end
    base_left--;
    if ($urandom_range(0, 9) == 0) return mbi_pkg::READING_W'($urandom_range(0, 1023));
    return clamp_reading(base_reading + int'($urandom_range(0, 2)) - 1);
  endfunction

  // Sink side: ready changes on the falling edge.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ch.ready <= !hold_off(1'b0);
    end
  end

  // Both channels are sampled at the rising edge; results are checked before
  // the tick of the same edge is noted.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      seen_result.green_on = out_ch.green_on;
      seen_result.yellow_on = out_ch.yellow_on;
      seen_result.red_on = out_ch.red_on;
      seen_result.verdict_valid = out_ch.verdict_valid;
      seen_result.band = out_ch.band;
      seen_result.burst_sum = out_ch.burst_sum;
      sb.check_result(seen_result);
    end
    if (rst_n && in_ch.valid && in_ch.ready) sb.note_tick(in_ch.adc_reading);
  end

  task automatic send_tick(logic [mbi_pkg::READING_W-1:0] reading);
    while (hold_off(1'b1)) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.adc_reading <= reading;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic cfg_write(logic [mbi_pkg::CFG_IDX_W-1:0] idx,
                           logic [mbi_pkg::CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= data;
    sb.write_reg(idx, data);
    @(negedge clk);
  endtask

  task automatic drain_results();
    while (sb.pending() != 0) @(negedge clk);
  endtask

  // Reconfigure only once every outstanding result has come back.
  task automatic apply_settings(logic [15:0] ri, logic [15:0] si, logic [15:0] ui,
                                logic [mbi_pkg::LEVEL_W-1:0] dry,
                                logic [mbi_pkg::LEVEL_W-1:0] wet);
    drain_results();
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_write(mbi_pkg::REG_READING_INTERVAL, ri);
    cfg_write(mbi_pkg::REG_SAMPLING_INTERVAL, si);
    cfg_write(mbi_pkg::REG_UPDATE_INTERVAL, ui);
    cfg_write(mbi_pkg::REG_DRY_LEVEL, mbi_pkg::CFG_DATA_W'(dry));
    cfg_write(mbi_pkg::REG_WET_LEVEL, mbi_pkg::CFG_DATA_W'(wet));
    cfg_we <= 1'b0;
  endtask

  initial begin
    logic [15:0] ri, si, ui;
    logic [mbi_pkg::LEVEL_W-1:0] dl, wl;
    int phase_items;
    int phase;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.adc_reading = '0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;

    // Zero intervals, levels with bits above their width, and writes past the
    // register list, which must be ignored.
    cfg_write(mbi_pkg::REG_READING_INTERVAL, '0);
    cfg_write(mbi_pkg::REG_SAMPLING_INTERVAL, '0);
    cfg_write(mbi_pkg::REG_UPDATE_INTERVAL, '0);
    cfg_write(mbi_pkg::REG_DRY_LEVEL, 16'h5BFD);
    cfg_write(mbi_pkg::REG_WET_LEVEL, 16'hF000);
    for (int i = mbi_pkg::REG_WET_LEVEL + 1; i < (1 << mbi_pkg::CFG_IDX_W); i++)
      cfg_write(mbi_pkg::CFG_IDX_W'(i), 16'hFFFF);
    cfg_we <= 1'b0;

    // Extreme readings, then readings around the alert threshold.
    for (int i = 0; i < 24; i++)
      send_tick(i < 4 ? EDGE_READINGS[i] : 10'd767 + mbi_pkg::READING_W'(i % 3));
    in_ch.valid <= 1'b0;

    // Phases with fresh settings and a changing idling pattern.
    for (phase = 1; items_sent < ITEM_GOAL && phase < MAX_PHASES; phase++) begin
      flow = flow_t'(phase % 4);
      phase_items = 120;
      case (phase)
        1: begin
          // Longest intervals: the burst freezes and no refresh comes.
          apply_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 12'd3069, 12'd0);
          phase_items = 40;
        end
        2: apply_settings(16'd1, 16'd1, 16'd1, 12'd0, 12'd3069);
        3: apply_settings(16'd5, 16'd1, 16'd2, mbi_pkg::RST_DRY_LEVEL,
                          mbi_pkg::RST_WET_LEVEL);
        4: apply_settings(16'd3, 16'd1, 16'd4, 12'd1500, 12'd1500);
        default: begin
          ri = 16'($urandom_range(1, 24));
          si = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(2, 4)) : 16'd1;
          ui = 16'($urandom_range(1, 6));
          dl = mbi_pkg::LEVEL_W'($urandom_range(100, 3069));
          wl = ($urandom_range(0, 5) == 0) ? mbi_pkg::LEVEL_W'($urandom_range(0, 3069))
                                           : mbi_pkg::LEVEL_W'($urandom_range(0, dl));
          apply_settings(ri, si, ui, dl, wl);
        end
      endcase
      repeat (phase_items) send_tick(next_reading());
      in_ch.valid <= 1'b0;
    end

    // Let the last results come back, then a short quiet tail.
    drain_results();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (sb.pending() != 0) sb.report("ticks left without a result");
    if (sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== moisture_band_indicator_core.f =====
rtl/mbi_pkg.sv
rtl/mbi_if.sv
rtl/mbi_cfg.sv
rtl/mbi_tick.sv
rtl/moisture_band_indicator_core.sv
verif/tb_top.sv
